### rtl/aet_pkg.sv
// Shared types and constants of the arithmetic expression tokenizer.
`default_nettype none

package aet_pkg;

    // Saturating counter widths
    localparam int LINE_CNT_W = 16;
    localparam int COL_CNT_W  = 16;
    localparam int LEN_CNT_W  = 16;

    // Token field widths
    localparam int KIND_W   = 3;
    localparam int LINE_F_W = 16;
    localparam int COL_F_W  = 16;
    localparam int LEN_F_W  = 16;
    localparam int CHAR_W   = 8;

    localparam int TDATA_F_W = LINE_F_W + COL_F_W + LEN_F_W + CHAR_W;
    localparam int O_TDATA_W = ((TDATA_F_W + 7) / 8) * 8;
    localparam int PAD_W     = O_TDATA_W - TDATA_F_W;

    // Token group and queue sizing
    localparam int GRP_N     = 3;
    localparam int GRP_CNT_W = $clog2(GRP_N + 1);
    localparam int Q_DEPTH   = 4;
    localparam int Q_PTR_W   = $clog2(Q_DEPTH);
    localparam int Q_CNT_W   = $clog2(Q_DEPTH + 1);

    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
    localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2E;
    localparam logic [CHAR_W-1:0] CH_SLASH = 8'h2F;
    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_STAR  = 8'h2A;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;

    typedef enum logic [KIND_W-1:0] {
        KIND_NUMBER = 3'd0,
        KIND_PLUS   = 3'd1,
        KIND_MINUS  = 3'd2,
        KIND_STAR   = 3'd3,
        KIND_SLASH  = 3'd4,
        KIND_ERROR  = 3'd5,
        KIND_END    = 3'd6
    } t_kind;

    typedef struct packed {
        t_kind                kind;
        logic [LINE_F_W-1:0]  line;
        logic [COL_F_W-1:0]   col;
        logic [LEN_F_W-1:0]   len;
        logic [CHAR_W-1:0]    bad;
    } t_token;

    // Tokens released by one input word, slot 0 first
    typedef struct packed {
        t_token [GRP_N-1:0]   tok;
        logic [GRP_CNT_W-1:0] cnt;
    } t_group;

    typedef struct packed {
        logic   valid;
        t_group grp;
    } t_push;

    typedef struct packed {
        logic empty;
        logic full;
    } t_q_stat;

endpackage

`default_nettype wire

### rtl/aet_front.sv
// Scanner front end: per-byte state update and token group build.
`default_nettype none

module aet_front (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_accept,
    input  wire logic [aet_pkg::CHAR_W-1:0]  i_char,
    input  wire logic                        i_end,
    output aet_pkg::t_push                   o_push
);

    typedef enum logic [5:0] {
        MODE_IDLE    = 6'b000001,
        MODE_INT     = 6'b000010,
        MODE_DOT     = 6'b000100,
        MODE_FRAC    = 6'b001000,
        MODE_SLASH   = 6'b010000,
        MODE_COMMENT = 6'b100000
    } t_mode;

    localparam logic [aet_pkg::LINE_CNT_W-1:0] LINE_MAX = '1;
    localparam logic [aet_pkg::COL_CNT_W-1:0]  COL_MAX  = '1;
    localparam logic [aet_pkg::LEN_CNT_W-1:0]  LEN_MAX  = '1;

    t_mode                            r_mode,  n_mode;
    logic [aet_pkg::LINE_CNT_W-1:0]   r_line,  n_line;
    logic [aet_pkg::COL_CNT_W-1:0]    r_col,   n_col;
    logic [aet_pkg::COL_CNT_W-1:0]    r_start, n_start;
    logic [aet_pkg::LEN_CNT_W-1:0]    r_run,   n_run;

    aet_pkg::t_group                  grp;
    logic [aet_pkg::GRP_CNT_W-1:0]    k;
    logic                             do_flush;
    logic                             do_idle;
    logic                             char_digit;
    logic [aet_pkg::LINE_CNT_W-1:0]   line_inc;
    logic [aet_pkg::COL_CNT_W-1:0]    col_inc;
    logic [aet_pkg::LEN_CNT_W-1:0]    run_inc1;
    logic [aet_pkg::LEN_CNT_W-1:0]    run_inc2;

    function automatic aet_pkg::t_token mk_tok(
        input aet_pkg::t_kind                  kind,
        input logic [aet_pkg::LINE_CNT_W-1:0]  line,
        input logic [aet_pkg::COL_CNT_W-1:0]   col,
        input logic [aet_pkg::LEN_CNT_W-1:0]   len,
        input logic [aet_pkg::CHAR_W-1:0]      bad
    );
        aet_pkg::t_token t;
        t.kind = kind;
        t.line = aet_pkg::LINE_F_W'(line);
        t.col  = aet_pkg::COL_F_W'(col);
        t.len  = aet_pkg::LEN_F_W'(len);
        t.bad  = bad;
        return t;
    endfunction

    always_comb begin
        char_digit = (i_char >= aet_pkg::CH_ZERO) && (i_char <= aet_pkg::CH_NINE);
        line_inc = (r_line == LINE_MAX) ? r_line : r_line + 1'b1;
        col_inc  = (r_col == COL_MAX) ? r_col : r_col + 1'b1;
        run_inc1 = (r_run == LEN_MAX) ? r_run : r_run + 1'b1;
        run_inc2 = (r_run >= LEN_MAX - 1'b1) ? LEN_MAX : r_run + 2'd2;

        n_mode   = r_mode;
        n_line   = r_line;
        n_col    = r_col;
        n_start  = r_start;
        n_run    = r_run;
        grp      = '0;
        k        = '0;
        do_flush = 1'b0;
        do_idle  = 1'b0;

        if (i_end) begin
            do_flush = (r_mode != MODE_COMMENT);
        end else if (r_mode == MODE_COMMENT) begin
            if (i_char == aet_pkg::CH_LF) begin
                n_mode = MODE_IDLE;
                n_line = line_inc;
                n_col  = '0;
            end else begin
                n_col = col_inc;
            end
        end else if (r_mode == MODE_SLASH && i_char == aet_pkg::CH_SLASH) begin
            n_col  = col_inc;
            n_mode = MODE_COMMENT;
        end else if ((r_mode == MODE_INT || r_mode == MODE_FRAC) && char_digit) begin
            n_col = col_inc;
            n_run = run_inc1;
        end else if (r_mode == MODE_INT && i_char == aet_pkg::CH_DOT) begin
            n_col  = col_inc;
            n_mode = MODE_DOT;
        end else if (r_mode == MODE_DOT && char_digit) begin
            n_col  = col_inc;
            n_run  = run_inc2;
            n_mode = MODE_FRAC;
        end else begin
            do_flush = 1'b1;
            do_idle  = 1'b1;
        end

        // Held number or slash goes out ahead of anything the new byte makes
        if (do_flush) begin
            case (r_mode)
                MODE_INT, MODE_FRAC: begin
                    grp.tok[k] = mk_tok(aet_pkg::KIND_NUMBER, r_line, r_start, r_run, '0);
                    k = k + 1'b1;
                end
                MODE_DOT: begin
                    grp.tok[k] = mk_tok(aet_pkg::KIND_NUMBER, r_line, r_start, r_run, '0);
                    k = k + 1'b1;
                    grp.tok[k] = mk_tok(aet_pkg::KIND_ERROR, r_line, r_col,
                                        aet_pkg::LEN_CNT_W'(1), aet_pkg::CH_DOT);
                    k = k + 1'b1;
                end
                MODE_SLASH: begin
                    grp.tok[k] = mk_tok(aet_pkg::KIND_SLASH, r_line, r_start,
                                        aet_pkg::LEN_CNT_W'(1), '0);
                    k = k + 1'b1;
                end
                default: begin
                end
            endcase
        end

        if (do_idle) begin
            n_mode = MODE_IDLE;
            if (i_char == aet_pkg::CH_SPACE || i_char == aet_pkg::CH_TAB ||
                i_char == aet_pkg::CH_CR) begin
                n_col = col_inc;
            end else if (i_char == aet_pkg::CH_LF) begin
                n_line = line_inc;
                n_col  = '0;
            end else if (i_char == aet_pkg::CH_SLASH) begin
                n_col   = col_inc;
                n_start = col_inc;
                n_mode  = MODE_SLASH;
            end else if (char_digit) begin
                n_col   = col_inc;
                n_start = col_inc;
                n_run   = aet_pkg::LEN_CNT_W'(1);
                n_mode  = MODE_INT;
            end else begin
                n_col = col_inc;
                if (i_char == aet_pkg::CH_PLUS) begin
                    grp.tok[k] = mk_tok(aet_pkg::KIND_PLUS, r_line, col_inc,
                                        aet_pkg::LEN_CNT_W'(1), '0);
                end else if (i_char == aet_pkg::CH_MINUS) begin
                    grp.tok[k] = mk_tok(aet_pkg::KIND_MINUS, r_line, col_inc,
                                        aet_pkg::LEN_CNT_W'(1), '0);
                end else if (i_char == aet_pkg::CH_STAR) begin
                    grp.tok[k] = mk_tok(aet_pkg::KIND_STAR, r_line, col_inc,
                                        aet_pkg::LEN_CNT_W'(1), '0);
                end else begin
                    grp.tok[k] = mk_tok(aet_pkg::KIND_ERROR, r_line, col_inc,
                                        aet_pkg::LEN_CNT_W'(1), i_char);
                end
                k = k + 1'b1;
            end
        end

        // End token reports the column of the last byte; then back to reset values
        if (i_end) begin
            grp.tok[k] = mk_tok(aet_pkg::KIND_END, r_line, r_col, '0, '0);
            k = k + 1'b1;
            n_mode  = MODE_IDLE;
            n_line  = aet_pkg::LINE_CNT_W'(1);
            n_col   = '0;
            n_start = '0;
            n_run   = '0;
        end

        grp.cnt = k;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_IDLE;
            r_line  <= aet_pkg::LINE_CNT_W'(1);
            r_col   <= '0;
            r_start <= '0;
            r_run   <= '0;
        end else if (i_accept) begin
            r_mode  <= n_mode;
            r_line  <= n_line;
            r_col   <= n_col;
            r_start <= n_start;
            r_run   <= n_run;
        end
    end

    assign o_push.valid = i_accept && (k != '0);
    assign o_push.grp   = grp;

endmodule

`default_nettype wire

### rtl/aet_queue.sv
// Token group FIFO between scanner and output serializer.
`default_nettype none

module aet_queue (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire aet_pkg::t_push  i_push,
    input  wire logic            i_pop,
    output aet_pkg::t_group      o_head,
    output aet_pkg::t_q_stat     o_stat
);

    aet_pkg::t_group                r_mem [aet_pkg::Q_DEPTH];
    logic [aet_pkg::Q_PTR_W-1:0]    r_wr, n_wr;
    logic [aet_pkg::Q_PTR_W-1:0]    r_rd, n_rd;
    logic [aet_pkg::Q_CNT_W-1:0]    r_cnt, n_cnt;
    logic                           pop_ok;

    localparam logic [aet_pkg::Q_PTR_W-1:0] PTR_LAST = aet_pkg::Q_PTR_W'(aet_pkg::Q_DEPTH - 1);

    always_comb begin
        pop_ok = i_pop && (r_cnt != '0);
        n_wr   = i_push.valid ? ((r_wr == PTR_LAST) ? '0 : r_wr + 1'b1) : r_wr;
        n_rd   = pop_ok ? ((r_rd == PTR_LAST) ? '0 : r_rd + 1'b1) : r_rd;
        n_cnt  = r_cnt;
        if (i_push.valid && !pop_ok) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!i_push.valid && pop_ok) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.valid) begin
            r_mem[r_wr] <= i_push.grp;
        end
    end

    assign o_head       = r_mem[r_rd];
    assign o_stat.empty = (r_cnt == '0);
    assign o_stat.full  = (r_cnt == aet_pkg::Q_CNT_W'(aet_pkg::Q_DEPTH));

endmodule

`default_nettype wire

### rtl/aet_back.sv
// Output serializer: walks the head group one token per word.
`default_nettype none

module aet_back (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire aet_pkg::t_group   i_head,
    input  wire aet_pkg::t_q_stat  i_stat,
    input  wire logic              i_ready,
    output logic                   o_pop,
    output logic                   o_valid,
    output aet_pkg::t_token        o_tok,
    output logic                   o_last
);

    logic [aet_pkg::GRP_CNT_W-1:0] r_idx, n_idx;
    logic                          take;

    always_comb begin
        o_valid = !i_stat.empty;
        o_last  = (r_idx == aet_pkg::GRP_CNT_W'(i_head.cnt - 1'b1));
        case (r_idx)
            2'd1:    o_tok = i_head.tok[1];
            2'd2:    o_tok = i_head.tok[2];
            default: o_tok = i_head.tok[0];
        endcase
        take  = o_valid && i_ready;
        o_pop = take && o_last;
        n_idx = r_idx;
        if (take) begin
            n_idx = o_last ? '0 : r_idx + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else begin
            r_idx <= n_idx;
        end
    end

endmodule

`default_nettype wire

### rtl/arith_expr_tokenizer.sv
// Top level of the arithmetic expression tokenizer.
//
//  channel   dir  tdata                                  tuser       tlast
//  s_axis    in   [7:0] char_in                          -           end_of_input
//  m_axis    out  [15:0] line [31:16] column             [2:0] kind  last token of byte
//                 [47:32] length [55:48] bad_char
//
// One source byte is taken per cycle; its tokens (zero to three) go out one per
// cycle from a four-entry group FIFO, so throughput is set by the output port.
// The input stalls only while that FIFO is full.
// Reset (synchronous, active low) returns the scanner to line 1, column 0, and
// empties the FIFO; no clearing pass is needed.
`default_nettype none

module arith_expr_tokenizer (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    input  wire logic [7:0]                    i_s_axis_tdata,  // [7:0] char_in
    input  wire logic                          i_s_axis_tlast,
    output logic                               o_m_axis_tvalid,
    input  wire logic                          i_m_axis_tready,
    // [15:0] line_number, [31:16] column_number, [47:32] token_length, [55:48] bad_char
    output logic [aet_pkg::O_TDATA_W-1:0]      o_m_axis_tdata,
    output logic [aet_pkg::KIND_W-1:0]         o_m_axis_tuser,  // [2:0] token_kind
    output logic                               o_m_axis_tlast
);

    logic              s_acc;
    aet_pkg::t_push    w_push;
    aet_pkg::t_group   w_head;
    aet_pkg::t_q_stat  w_q_stat;
    logic              w_pop;
    aet_pkg::t_token   w_tok;

    assign o_s_axis_tready = !w_q_stat.full;
    assign s_acc           = i_s_axis_tvalid && o_s_axis_tready;

    aet_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (s_acc),
        .i_char   (i_s_axis_tdata),
        .i_end    (i_s_axis_tlast),
        .o_push   (w_push)
    );

    aet_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_stat  (w_q_stat)
    );

    aet_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (w_head),
        .i_stat  (w_q_stat),
        .i_ready (i_m_axis_tready),
        .o_pop   (w_pop),
        .o_valid (o_m_axis_tvalid),
        .o_tok   (w_tok),
        .o_last  (o_m_axis_tlast)
    );

    assign o_m_axis_tuser = w_tok.kind;
    assign o_m_axis_tdata = aet_pkg::O_TDATA_W'({w_tok.bad, w_tok.len, w_tok.col, w_tok.line});

    // End marker always releases at least the end token
    a_end_pushes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_acc && i_s_axis_tlast) |-> w_push.valid)
        else $error("end marker produced no tokens");

    // A pushed group is never empty
    a_grp_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push.valid |-> (w_push.grp.cnt != '0))
        else $error("empty token group pushed");

    // A full queue always offers a word downstream
    a_full_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_stat.full |-> o_m_axis_tvalid)
        else $error("queue full without output valid");

    // End token is the final token of its byte
    a_end_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && (o_m_axis_tuser == aet_pkg::KIND_END)) |-> o_m_axis_tlast)
        else $error("end token without tlast");

endmodule

`default_nettype wire

### sim/tb_arith_expr_tokenizer.sv
// Self-checking testbench for the arithmetic expression tokenizer.
`default_nettype none

module tb_arith_expr_tokenizer;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          STALL_LIMIT = 2000;
    localparam logic [15:0] CNT_MAX     = 16'hFFFF;
    localparam logic [7:0]  CH_X        = 8'h78;

    typedef enum {SCAN_IDLE, SCAN_INT, SCAN_DOT, SCAN_FRAC, SCAN_SLASH, SCAN_COMMENT} t_scan;

    typedef struct packed {
        aet_pkg::t_kind kind;
        logic [15:0]    line;
        logic [15:0]    col;
        logic [15:0]    len;
        logic [7:0]     bad;
        logic           last;
    } t_tok;

    // one source word; when pin is set the fields below are the typed-in final token
    typedef struct packed {
        logic [7:0]     ch;
        logic           eoi;
        logic           pin;
        aet_pkg::t_kind kind;
        logic [15:0]    line;
        logic [15:0]    col;
        logic [15:0]    len;
        logic [7:0]     bad;
    } t_row;

    localparam t_row DIR_TAB [0:28] = '{
        '{aet_pkg::CH_PLUS,  1'b0, 1'b1, aet_pkg::KIND_PLUS,   16'd1, 16'd1,  16'd1, 8'h00},
        '{aet_pkg::CH_MINUS, 1'b0, 1'b1, aet_pkg::KIND_MINUS,  16'd1, 16'd2,  16'd1, 8'h00},
        '{aet_pkg::CH_STAR,  1'b0, 1'b1, aet_pkg::KIND_STAR,   16'd1, 16'd3,  16'd1, 8'h00},
        '{8'h00,             1'b0, 1'b1, aet_pkg::KIND_ERROR,  16'd1, 16'd4,  16'd1, 8'h00},
        '{8'hFF,             1'b0, 1'b1, aet_pkg::KIND_ERROR,  16'd1, 16'd5,  16'd1, 8'hFF},
        '{aet_pkg::CH_SPACE, 1'b0, 1'b0, aet_pkg::KIND_NUMBER, 16'd0, 16'd0,  16'd0, 8'h00},
        '{aet_pkg::CH_TAB,   1'b0, 1'b0, aet_pkg::KIND_NUMBER, 16'd0, 16'd0,  16'd0, 8'h00},
        '{aet_pkg::CH_CR,    1'b0, 1'b0, aet_pkg::KIND_NUMBER, 16'd0, 16'd0,  16'd0, 8'h00},
        '{aet_pkg::CH_ZERO,  1'b0, 1'b0, aet_pkg::KIND_NUMBER, 16'd0, 16'd0,  16'd0, 8'h00},
        '{aet_pkg::CH_DOT,   1'b0, 1'b0, aet_pkg::KIND_NUMBER, 16'd0, 16'd0,  16'd0, 8'h00},
        '{8'h35,             1'b0, 1'b0, aet_pkg::KIND_NUMBER, 16'd0, 16'd0,  16'd0, 8'h00},
        '{aet_pkg::CH_PLUS,  1'b0, 1'b1, aet_pkg::KIND_PLUS,   16'd1, 16'd12, 16'd1, 8'h00},
        '{aet_pkg::CH_NINE,  1'b0, 1'b0, aet_pkg::KIND_NUMBER, 16'd0, 16'd0,  16'd0, 8'h00},
        '{aet_pkg::CH_DOT,   1'b0, 1'b0, aet_pkg::KIND_NUMBER, 16'd0, 16'd0,  16'd0, 8'h00},
        // dot without digit: number, dot error, then this byte
        '{CH_X,              1'b0, 1'b1, aet_pkg::KIND_ERROR,  16'd1, 16'd15, 16'd1, CH_X},
        '{aet_pkg::CH_SLASH, 1'b0, 1'b0, aet_pkg::KIND_NUMBER, 16'd0, 16'd0,  16'd0, 8'h00},
        '{8'h37,             1'b0, 1'b0, aet_pkg::KIND_NUMBER, 16'd0, 16'd0,  16'd0, 8'h00},
        '{aet_pkg::CH_SLASH, 1'b0, 1'b0, aet_pkg::KIND_NUMBER, 16'd0, 16'd0,  16'd0, 8'h00},
        '{aet_pkg::CH_SLASH, 1'b0, 1'b0, aet_pkg::KIND_NUMBER, 16'd0, 16'd0,  16'd0, 8'h00},
        '{aet_pkg::CH_LF,    1'b0, 1'b0, aet_pkg::KIND_NUMBER, 16'd0, 16'd0,  16'd0, 8'h00},
        '{aet_pkg::CH_SLASH, 1'b0, 1'b0, aet_pkg::KIND_NUMBER, 16'd0, 16'd0,  16'd0, 8'h00},
        '{aet_pkg::CH_SLASH, 1'b0, 1'b0, aet_pkg::KIND_NUMBER, 16'd0, 16'd0,  16'd0, 8'h00},
        // end inside a comment: end token only
        '{8'h5A,             1'b1, 1'b1, aet_pkg::KIND_END,    16'd2, 16'd2,  16'd0, 8'h00},
        '{8'h34,             1'b0, 1'b0, aet_pkg::KIND_NUMBER, 16'd0, 16'd0,  16'd0, 8'h00},
        '{aet_pkg::CH_DOT,   1'b0, 1'b0, aet_pkg::KIND_NUMBER, 16'd0, 16'd0,  16'd0, 8'h00},
        '{8'hA5,             1'b1, 1'b1, aet_pkg::KIND_END,    16'd1, 16'd2,  16'd0, 8'h00},
        '{aet_pkg::CH_SLASH, 1'b0, 1'b0, aet_pkg::KIND_NUMBER, 16'd0, 16'd0,  16'd0, 8'h00},
        '{8'hFF,             1'b1, 1'b1, aet_pkg::KIND_END,    16'd1, 16'd1,  16'd0, 8'h00},
        '{8'h00,             1'b1, 1'b1, aet_pkg::KIND_END,    16'd1, 16'd0,  16'd0, 8'h00}
    };

    logic                          i_clk   = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          s_valid = 1'b0;
    logic [7:0]                    s_data  = 8'h00;
    logic                          s_last  = 1'b0;
    t_row                          s_row   = '0;
    logic                          m_ready = 1'b0;
    logic                          o_s_axis_tready;
    logic                          o_m_axis_tvalid;
    logic [aet_pkg::O_TDATA_W-1:0] o_m_axis_tdata;
    logic [aet_pkg::KIND_W-1:0]    o_m_axis_tuser;
    logic                          o_m_axis_tlast;

    arith_expr_tokenizer dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tlast  (s_last),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    always #6 i_clk = ~i_clk;

    // scanner shadow state
    t_scan       sc_mode  = SCAN_IDLE;
    logic [15:0] sc_line  = 16'd1;
    logic [15:0] sc_col   = 16'd0;
    logic [15:0] sc_start = 16'd0;
    logic [15:0] sc_run   = 16'd0;
    t_tok        grp[$];
    t_tok        tok_due[$];

    int  n_err    = 0;
    int  n_words  = 0;
    int  n_ends   = 0;
    int  n_toks   = 0;
    int  stall    = 0;
    int  rx_left  = 0;

    function automatic logic [15:0] sat_add16(logic [15:0] v, int unsigned d);
        int unsigned s;
        s = v + d;
        return (s > 32'hFFFF) ? CNT_MAX : s[15:0];
    endfunction

    function automatic bit digit_chr(logic [7:0] c);
        return c >= aet_pkg::CH_ZERO && c <= aet_pkg::CH_NINE;
    endfunction

    function automatic string fmt_tok(t_tok t);
        return $sformatf("kind=%0d line=%0d col=%0d len=%0d bad=%02h last=%0b",
                         t.kind, t.line, t.col, t.len, t.bad, t.last);
    endfunction

    function void note_tok(aet_pkg::t_kind k, logic [15:0] c, logic [15:0] l,
                           logic [7:0] b);
        t_tok t;
        t.kind = k;
        t.line = sc_line;
        t.col  = c;
        t.len  = l;
        t.bad  = b;
        t.last = 1'b0;
        grp.push_back(t);
    endfunction

    function void take_byte();
        sc_col = sat_add16(sc_col, 1);
    endfunction

    // byte seen with nothing held
    function void scan_fresh(logic [7:0] c);
        if (c == aet_pkg::CH_SPACE || c == aet_pkg::CH_TAB || c == aet_pkg::CH_CR) begin
            take_byte();
        end else if (c == aet_pkg::CH_LF) begin
            sc_line = sat_add16(sc_line, 1);
            sc_col  = 16'd0;
        end else if (c == aet_pkg::CH_SLASH) begin
            take_byte();
            sc_start = sc_col;
            sc_mode  = SCAN_SLASH;
        end else if (digit_chr(c)) begin
            take_byte();
            sc_start = sc_col;
            sc_run   = 16'd1;
            sc_mode  = SCAN_INT;
        end else begin
            take_byte();
            if (c == aet_pkg::CH_PLUS)
                note_tok(aet_pkg::KIND_PLUS, sc_col, 16'd1, 8'h00);
            else if (c == aet_pkg::CH_MINUS)
                note_tok(aet_pkg::KIND_MINUS, sc_col, 16'd1, 8'h00);
            else if (c == aet_pkg::CH_STAR)
                note_tok(aet_pkg::KIND_STAR, sc_col, 16'd1, 8'h00);
            else
                note_tok(aet_pkg::KIND_ERROR, sc_col, 16'd1, c);
        end
    endfunction

    function void release_held();
        case (sc_mode)
            SCAN_INT, SCAN_FRAC: begin
                note_tok(aet_pkg::KIND_NUMBER, sc_start, sc_run, 8'h00);
            end
            SCAN_DOT: begin
                note_tok(aet_pkg::KIND_NUMBER, sc_start, sc_run, 8'h00);
                note_tok(aet_pkg::KIND_ERROR, sc_col, 16'd1, aet_pkg::CH_DOT);
            end
            SCAN_SLASH: begin
                note_tok(aet_pkg::KIND_SLASH, sc_start, 16'd1, 8'h00);
            end
            default: ;
        endcase
        sc_mode = SCAN_IDLE;
    endfunction

    // tokens released by one source word land in grp
    function void tokenize_byte(logic [7:0] c, logic eoi);
        grp = {};
        if (eoi) begin
            if (sc_mode != SCAN_COMMENT)
                release_held();
            note_tok(aet_pkg::KIND_END, sc_col, 16'd0, 8'h00);
            sc_mode  = SCAN_IDLE;
            sc_line  = 16'd1;
            sc_col   = 16'd0;
            sc_start = 16'd0;
            sc_run   = 16'd0;
        end else if (sc_mode == SCAN_COMMENT) begin
            if (c == aet_pkg::CH_LF) begin
                sc_mode = SCAN_IDLE;
                scan_fresh(c);
            end else begin
                take_byte();
            end
        end else if (sc_mode == SCAN_SLASH && c == aet_pkg::CH_SLASH) begin
            take_byte();
            sc_mode = SCAN_COMMENT;
        end else if ((sc_mode == SCAN_INT || sc_mode == SCAN_FRAC) && digit_chr(c)) begin
            take_byte();
            sc_run = sat_add16(sc_run, 1);
        end else if (sc_mode == SCAN_INT && c == aet_pkg::CH_DOT) begin
            take_byte();
            sc_mode = SCAN_DOT;
        end else if (sc_mode == SCAN_DOT && digit_chr(c)) begin
            take_byte();
            sc_run  = sat_add16(sc_run, 2);
            sc_mode = SCAN_FRAC;
        end else begin
            release_held();
            scan_fresh(c);
        end
    endfunction

    // handshakes are judged at the falling edge, where every signal is settled
    always @(negedge i_clk) begin : watch
        t_tok got;
        t_tok want;
        bit   moved;
        int   n;
        moved = 1'b0;
        if (i_rst_n && s_valid && o_s_axis_tready) begin
            moved = 1'b1;
            n_words++;
            if (s_last)
                n_ends++;
            tokenize_byte(s_data, s_last);
            n = grp.size();
            if (n > 0) begin
                want = grp[n-1];
                want.last = 1'b1;
                if (s_row.pin) begin
                    want.kind = s_row.kind;
                    want.line = s_row.line;
                    want.col  = s_row.col;
                    want.len  = s_row.len;
                    want.bad  = s_row.bad;
                end
                grp[n-1] = want;
            end
            foreach (grp[i])
                tok_due.push_back(grp[i]);
        end
        if (i_rst_n && o_m_axis_tvalid && m_ready) begin
            moved = 1'b1;
            n_toks++;
            got.kind = aet_pkg::t_kind'(o_m_axis_tuser);
            got.line = o_m_axis_tdata[15:0];
            got.col  = o_m_axis_tdata[31:16];
            got.len  = o_m_axis_tdata[47:32];
            got.bad  = o_m_axis_tdata[55:48];
            got.last = o_m_axis_tlast;
            if (tok_due.size() == 0) begin
                $display("%0t: token mismatch expected none actual %s",
                         $time, fmt_tok(got));
                n_err++;
            end else begin
                want = tok_due.pop_front();
                if (got !== want) begin
                    $display("%0t: token mismatch expected %s actual %s",
                             $time, fmt_tok(want), fmt_tok(got));
                    n_err++;
                end
            end
        end
        if (moved) begin
            stall = 0;
        end else begin
            stall++;
            if (stall >= STALL_LIMIT) begin
                $display("%0t: no word moved for %0d cycles, %0d tokens outstanding",
                         $time, stall, tok_due.size());
                $display("tb_arith_expr_tokenizer: errors");
                $finish;
            end
        end
    end

    // output side back-pressure
    always @(posedge i_clk) begin : rx_drive
        int r;
        r = $urandom_range(0, 99);
        if (rx_left > 0) begin
            rx_left--;
        end else if (!m_ready) begin
            m_ready <= 1'b1;
            rx_left = (r < 10) ? $urandom_range(30, 60) : $urandom_range(0, 10);
        end else begin
            m_ready <= 1'b0;
            rx_left = (r < 70) ? 0 : (r < 95) ? $urandom_range(1, 4) : $urandom_range(15, 40);
        end
    end

    function automatic int tx_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 30);
    endfunction

    function automatic t_row plain(logic [7:0] c, logic eoi);
        t_row r;
        r      = '0;
        r.ch   = c;
        r.eoi  = eoi;
        r.kind = aet_pkg::KIND_NUMBER;
        return r;
    endfunction

    // called at a rising edge, returns at the edge that takes the word
    task automatic put_word(t_row r);
        int g;
        g = tx_gap();
        if (g > 0) begin
            s_valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        s_valid <= 1'b1;
        s_data  <= r.ch;
        s_last  <= r.eoi;
        s_row   <= r;
        do @(negedge i_clk); while (!o_s_axis_tready);
        @(posedge i_clk);
    endtask

    task automatic hold_until_drained();
        s_valid <= 1'b0;
        while (tok_due.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic put_digits(int n);
        repeat (n) put_word(plain(8'(aet_pkg::CH_ZERO + $urandom_range(0, 9)), 1'b0));
    endtask

    // mostly well-formed expressions, with junk bytes and stray ends mixed in
    task automatic rand_source(int target);
        int n;
        int r;
        int k;
        logic [7:0] c;
        n = 0;
        while (n < target) begin
            r = $urandom_range(0, 99);
            if (r < 30) begin
                k = $urandom_range(1, 4);
                put_digits(k);
                n += k;
                if ($urandom_range(0, 2) == 0) begin
                    put_word(plain(aet_pkg::CH_DOT, 1'b0));
                    n++;
                    if ($urandom_range(0, 3) != 0) begin
                        k = $urandom_range(1, 3);
                        put_digits(k);
                        n += k;
                    end
                end
            end else if (r < 50) begin
                case ($urandom_range(0, 3))
                    0: c = aet_pkg::CH_PLUS;
                    1: c = aet_pkg::CH_MINUS;
                    2: c = aet_pkg::CH_STAR;
                    default: c = aet_pkg::CH_SLASH;
                endcase
                put_word(plain(c, 1'b0));
                n++;
            end else if (r < 60) begin
                repeat ($urandom_range(1, 3)) begin
                    case ($urandom_range(0, 2))
                        0: c = aet_pkg::CH_SPACE;
                        1: c = aet_pkg::CH_TAB;
                        default: c = aet_pkg::CH_CR;
                    endcase
                    put_word(plain(c, 1'b0));
                end
            end else if (r < 66) begin
                put_word(plain(aet_pkg::CH_LF, 1'b0));
            end else if (r < 72) begin
                put_word(plain(aet_pkg::CH_SLASH, 1'b0));
                put_word(plain(aet_pkg::CH_SLASH, 1'b0));
                n += 2;
                repeat ($urandom_range(0, 5))
                    put_word(plain(8'($urandom_range(32, 126)), 1'b0));
                put_word(plain(aet_pkg::CH_LF, 1'b0));
            end else if (r < 80) begin
                put_word(plain(aet_pkg::CH_DOT, 1'b0));
                n++;
            end else if (r < 92) begin
                put_word(plain(8'($urandom_range(0, 255)), 1'b0));
                n++;
            end else begin
                put_word(plain(8'($urandom_range(0, 255)), 1'b1));
                n++;
            end
        end
        put_word(plain(8'($urandom_range(0, 255)), 1'b1));
    endtask

    initial begin : stim
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (DIR_TAB[i])
            put_word(DIR_TAB[i]);
        hold_until_drained();

        rand_source(45);
        hold_until_drained();
        rand_source(45);
        hold_until_drained();

        repeat (16) @(posedge i_clk);
        if (tok_due.size() != 0) begin
            $display("%0t: %0d tokens never arrived, first %s",
                     $time, tok_due.size(), fmt_tok(tok_due[0]));
            n_err += tok_due.size();
        end
        $display("run: %0d source words (%0d end markers), %0d tokens checked",
                 n_words, n_ends, n_toks);
        $display("run: directed table plus random expressions with comments and junk, %s",
                 "random stalls on both sides");
        if (n_err == 0) begin
            $display("tb_arith_expr_tokenizer: clean");
        end else begin
            $display("tb_arith_expr_tokenizer: errors");
        end
        $finish;
    end

endmodule

`default_nettype wire
